// File: rtl/pptf_pkg.sv
`timescale 1ns / 1ps

package pptf_pkg;

  // geometry of the history store
  localparam int MAX_PIXELS   = 16384;
  localparam int FILTER_ORDER = 6;
  localparam int POS_W        = $clog2(MAX_PIXELS);
  localparam int FRAME_W      = POS_W + 1;

  // number formats
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(FILTER_ORDER + 1);
  localparam int FRAC_SHIFT = 16;
  localparam int Y_W        = ACC_W - FRAC_SHIFT;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_SHIFT - 1));
  localparam logic signed [Y_W-1:0]   Y_HI       = Y_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [Y_W-1:0]   Y_LO       = Y_W'(-(2 ** (SAMPLE_W - 1)));

  // register reset values
  localparam logic [COEF_W-1:0]  GAIN_B0_RESET = COEF_W'(65536);
  localparam logic [FRAME_W-1:0] PPF_RESET     = FRAME_W'(16384);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_B0          = 3'd0,
    REG_FB_COEF_1        = 3'd1,
    REG_FB_COEF_2        = 3'd2,
    REG_FB_COEF_3        = 3'd3,
    REG_FB_COEF_4        = 3'd4,
    REG_FB_COEF_5        = 3'd5,
    REG_FB_COEF_6        = 3'd6,
    REG_PIXELS_PER_FRAME = 3'd7
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_word_t;

  // one pixel's past outputs, entry k is k+1 frames back
  typedef sample_t [FILTER_ORDER-1:0] hist_row_t;

  typedef struct packed {
    coef_word_t                      gain_b0;
    coef_word_t [FILTER_ORDER-1:0]   fb;
  } coef_t;

  typedef struct packed {
    sample_t filtered;
    logic    saturated;
  } result_t;

endpackage

// File: rtl/pptf_hist_mem.sv
`timescale 1ns / 1ps

module pptf_hist_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pptf_pkg::POS_W-1:0] wr_addr,
  input  pptf_pkg::hist_row_t        wr_row,
  input  logic                       rd_en,
  input  logic [pptf_pkg::POS_W-1:0] rd_addr,
  output pptf_pkg::hist_row_t        rd_row
);

  pptf_pkg::hist_row_t mem [pptf_pkg::MAX_PIXELS];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // one registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pptf_filter_dp.sv
`timescale 1ns / 1ps

module pptf_filter_dp (
  input  pptf_pkg::sample_t   sample,
  input  pptf_pkg::hist_row_t row,
  input  pptf_pkg::coef_t     coef,
  output pptf_pkg::result_t   res,
  output pptf_pkg::hist_row_t new_row
);

  logic signed [pptf_pkg::ACC_W-1:0] acc;
  logic signed [pptf_pkg::Y_W-1:0]   y_wide;

  // b0*x minus the feedback products, exact
  always_comb begin
    logic signed [pptf_pkg::PROD_W-1:0] prod_ff;
    logic signed [pptf_pkg::PROD_W-1:0] prod_fb;
    prod_ff = $signed(coef.gain_b0) * $signed(sample);
    acc     = pptf_pkg::ACC_W'(prod_ff);
    for (int k = 0; k < pptf_pkg::FILTER_ORDER; k++) begin
      prod_fb = $signed(coef.fb[k]) * $signed(row[k]);
      acc     = acc - pptf_pkg::ACC_W'(prod_fb);
    end
  end

  // round half up, dropping the 16 fraction bits of the Q8.16 coefficients, then clip
  always_comb begin
    logic signed [pptf_pkg::ACC_W-1:0] rnd;
    rnd    = acc + pptf_pkg::ROUND_HALF;
    y_wide = pptf_pkg::Y_W'(rnd >>> pptf_pkg::FRAC_SHIFT);
    if (y_wide > pptf_pkg::Y_HI) begin
      res.filtered  = pptf_pkg::SAMPLE_W'(pptf_pkg::Y_HI);
      res.saturated = 1'b1;
    end else if (y_wide < pptf_pkg::Y_LO) begin
      res.filtered  = pptf_pkg::SAMPLE_W'(pptf_pkg::Y_LO);
      res.saturated = 1'b1;
    end else begin
      res.filtered  = pptf_pkg::SAMPLE_W'(y_wide);
      res.saturated = 1'b0;
    end
  end

  // shift the pixel's history by one frame
  always_comb begin
    new_row[0] = res.filtered;
    for (int k = 1; k < pptf_pkg::FILTER_ORDER; k++) begin
      new_row[k] = row[k-1];
    end
  end

endmodule

// File: rtl/per_pixel_iir_temporal_filter.sv
`timescale 1ns / 1ps
// a sample beat passes the compute stage register, then the result register, which holds under result_stall
// throughput: one pixel per cycle while sample_stall is low, with the history read-modify-write
// forwarding the row when consecutive beats hit the same pixel
// reset: registers return to defaults, then a clearing pass zeroes all 16384 rows of
// the history memory one row per cycle while sample_stall is held high
module per_pixel_iir_temporal_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pptf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pptf_pkg::COEF_W-1:0]    cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [23:0]             sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [23:0]             filtered,
  output logic                           saturated,
  output logic                           frame_end
);

  pptf_pkg::coef_t                coef;
  logic [pptf_pkg::FRAME_W-1:0]   pixels_per_frame;

  logic                           clear_busy;
  logic [pptf_pkg::POS_W-1:0]     clear_addr;

  logic [pptf_pkg::POS_W-1:0]     pixel_position;
  logic [pptf_pkg::POS_W-1:0]     pixel_position_next;
  logic [pptf_pkg::FRAME_W-1:0]   frame_len;
  logic [pptf_pkg::POS_W-1:0]     pos0;
  logic                           last0;

  logic                           s1_valid;
  pptf_pkg::sample_t              s1_sample;
  logic [pptf_pkg::POS_W-1:0]     s1_pos;
  logic                           s1_last;
  logic                           s1_fwd;
  pptf_pkg::hist_row_t            s1_fwd_row;

  pptf_pkg::hist_row_t            mem_row;
  pptf_pkg::hist_row_t            s1_row;
  pptf_pkg::hist_row_t            new_row;
  pptf_pkg::result_t              res;

  logic                           accept;
  logic                           out_free;
  logic                           s1_move;
  logic                           mem_we;
  logic [pptf_pkg::POS_W-1:0]     mem_waddr;
  pptf_pkg::hist_row_t            mem_wrow;

  // handshake
  assign out_free     = !result_valid || !result_stall;
  assign s1_move      = s1_valid && out_free;
  assign sample_stall = clear_busy || (s1_valid && !out_free);
  assign accept       = sample_valid && !sample_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.gain_b0     <= pptf_pkg::GAIN_B0_RESET;
      coef.fb          <= '0;
      pixels_per_frame <= pptf_pkg::PPF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pptf_pkg::REG_GAIN_B0: begin
          coef.gain_b0 <= cfg_data;
        end
        pptf_pkg::REG_FB_COEF_1, pptf_pkg::REG_FB_COEF_2, pptf_pkg::REG_FB_COEF_3,
        pptf_pkg::REG_FB_COEF_4, pptf_pkg::REG_FB_COEF_5, pptf_pkg::REG_FB_COEF_6: begin
          coef.fb[pptf_pkg::CFG_IDX_W'(cfg_index - 3'd1)] <= cfg_data;
        end
        pptf_pkg::REG_PIXELS_PER_FRAME: begin
          pixels_per_frame <= pptf_pkg::FRAME_W'(cfg_data);
        end
      endcase
    end
  end

  // effective frame length and position of the incoming pixel
  always_comb begin
    if (pixels_per_frame == '0) begin
      frame_len = pptf_pkg::FRAME_W'(1);
    end else if (pixels_per_frame > pptf_pkg::FRAME_W'(pptf_pkg::MAX_PIXELS)) begin
      frame_len = pptf_pkg::FRAME_W'(pptf_pkg::MAX_PIXELS);
    end else begin
      frame_len = pixels_per_frame;
    end
    if ({1'b0, pixel_position} >= frame_len) begin
      pos0 = pptf_pkg::POS_W'(frame_len - pptf_pkg::FRAME_W'(1));
    end else begin
      pos0 = pixel_position;
    end
    last0 = ({1'b0, pos0} + pptf_pkg::FRAME_W'(1)) >= frame_len;
    pixel_position_next = last0 ? '0 : pos0 + pptf_pkg::POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
    end else if (accept) begin
      pixel_position <= pixel_position_next;
    end
  end

  // clearing pass over the history after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      if (clear_addr == pptf_pkg::POS_W'(pptf_pkg::MAX_PIXELS - 1)) begin
        clear_busy <= 1'b0;
      end
      clear_addr <= clear_addr + pptf_pkg::POS_W'(1);
    end
  end

  // history write port: clearing pass, else the retiring pixel
  always_comb begin
    if (clear_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wrow  = '0;
    end else begin
      mem_we    = s1_move;
      mem_waddr = s1_pos;
      mem_wrow  = new_row;
    end
  end

  pptf_hist_mem u_hist (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_row  (mem_wrow),
    .rd_en   (accept),
    .rd_addr (pos0),
    .rd_row  (mem_row)
  );

  // compute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // compute stage payload, forward the row being written to the same pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample  <= sample;
      s1_pos     <= pos0;
      s1_last    <= last0;
      s1_fwd     <= s1_move && (s1_pos == pos0);
      s1_fwd_row <= new_row;
    end
  end

  assign s1_row = s1_fwd ? s1_fwd_row : mem_row;

  pptf_filter_dp u_dp (
    .sample  (s1_sample),
    .row     (s1_row),
    .coef    (coef),
    .res     (res),
    .new_row (new_row)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      filtered  <= res.filtered;
      saturated <= res.saturated;
      frame_end <= s1_last;
    end
  end

endmodule

// File: rtl/pptf_checker.sv
`timescale 1ns / 1ps

module pptf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic signed [23:0]             filtered,
  input logic                           saturated,
  input logic                           frame_end
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // input is held off as the history clearing starts after reset
  a_clear_stall: assert property (@(posedge clk) $past(rst) && !rst |-> sample_stall)
    else $error("sample accepted before history clear");

  // a clipped result sits on one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> filtered == 24'sh7fffff || filtered == 24'sh800000)
    else $error("saturated result not at a range limit");

  // a stalled result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered)
      && $stable(saturated) && $stable(frame_end))
    else $error("stalled result beat changed");

endmodule

bind per_pixel_iir_temporal_filter pptf_checker u_pptf_checker (.*);

// File: sim/per_pixel_iir_temporal_filter_test.sv
`timescale 1ns / 1ps

module per_pixel_iir_temporal_filter_test;

  localparam int     STALL_LIMIT  = 100000;
  localparam int     LONG_HOLD    = 300;
  localparam int     RAND_PHASES  = 12;
  localparam int     PHASE_PIXELS = 128;
  localparam longint OUT_MAX      = 64'sd8388607;
  localparam longint OUT_MIN      = -64'sd8388608;

  typedef struct packed {
    pptf_pkg::sample_t filtered;
    logic              saturated;
    logic              frame_end;
  } pixel_result_t;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    pptf_pkg::cfg_reg_e idx;
    logic [23:0]        data;
    bit                 typed;
    pixel_result_t      want;
  } stim_row_t;

  typedef enum logic [2:0] {
    SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE, SINK_CHUNKS
  } sink_mode_e;

  typedef enum logic [1:0] {FB_OFF, FB_STABLE, FB_WILD, FB_EXTREME} fb_mode_e;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [pptf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pptf_pkg::COEF_W-1:0]    cfg_data;
  logic                           sample_valid;
  logic                           sample_stall;
  logic signed [23:0]             sample;
  logic                           result_valid;
  logic                           result_stall;
  logic signed [23:0]             filtered;
  logic                           saturated;
  logic                           frame_end;

  per_pixel_iir_temporal_filter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .saturated    (saturated),
    .frame_end    (frame_end)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // filter state as the block should hold it
  pptf_pkg::sample_t    hist_mem [pptf_pkg::FILTER_ORDER][pptf_pkg::MAX_PIXELS];
  pptf_pkg::coef_word_t gain_q;
  pptf_pkg::coef_word_t fb_q [pptf_pkg::FILTER_ORDER];
  logic [14:0]          frame_len_q;
  int unsigned          next_pos;

  pixel_result_t pending_pixels [$];
  stim_row_t     stim_rows [$];
  int            pixels_taken;
  int            results_seen;
  int            fail_count;
  int            hold_requests;
  int            idle_cycles;

  // expectation handed over by the driver for the beat on offer
  bit            pin_typed;
  pixel_result_t pin_want;

  function automatic void clear_model();
    for (int k = 0; k < pptf_pkg::FILTER_ORDER; k++) begin
      for (int p = 0; p < pptf_pkg::MAX_PIXELS; p++) hist_mem[k][p] = '0;
      fb_q[k] = '0;
    end
    gain_q      = pptf_pkg::GAIN_B0_RESET;
    frame_len_q = 15'd16384;
    next_pos    = 0;
  endfunction

  function automatic void apply_reg(pptf_pkg::cfg_reg_e idx, logic [23:0] data);
    case (idx)
      pptf_pkg::REG_GAIN_B0: gain_q = data;
      pptf_pkg::REG_FB_COEF_1, pptf_pkg::REG_FB_COEF_2, pptf_pkg::REG_FB_COEF_3,
      pptf_pkg::REG_FB_COEF_4, pptf_pkg::REG_FB_COEF_5,
      pptf_pkg::REG_FB_COEF_6: fb_q[int'(idx) - 1] = data;
      pptf_pkg::REG_PIXELS_PER_FRAME: frame_len_q = data[14:0];
      default: ;
    endcase
  endfunction

  // one pixel through the filter: feed-forward, feedback, round, clip, shift history
  function automatic pixel_result_t filter_pixel(pptf_pkg::sample_t x);
    pixel_result_t r;
    int unsigned   len;
    int unsigned   p;
    longint        acc;
    longint        y;
    len = frame_len_q;
    if (len == 0) len = 1;
    if (len > pptf_pkg::MAX_PIXELS) len = pptf_pkg::MAX_PIXELS;
    p = next_pos;
    if (p >= len) p = len - 1;
    acc = longint'(gain_q) * longint'(x);
    for (int k = 0; k < pptf_pkg::FILTER_ORDER; k++)
      acc -= longint'(fb_q[k]) * longint'(hist_mem[k][p]);
    y = (acc + 64'sd32768) >>> 16;
    r.saturated = 1'b0;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      r.saturated = 1'b1;
    end
    if (y < OUT_MIN) begin
      y = OUT_MIN;
      r.saturated = 1'b1;
    end
    for (int k = pptf_pkg::FILTER_ORDER - 1; k > 0; k--) hist_mem[k][p] = hist_mem[k-1][p];
    hist_mem[0][p] = pptf_pkg::sample_t'(y);
    r.filtered  = pptf_pkg::sample_t'(y);
    r.frame_end = (p + 1 >= len);
    next_pos    = r.frame_end ? 0 : p + 1;
    return r;
  endfunction

  // beat monitor: predict on accepted samples, compare accepted results
  always @(posedge clk) begin : beat_monitor
    pixel_result_t want;
    pixel_result_t got;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        want = filter_pixel(sample);
        if (pin_typed) want = pin_want;
        pending_pixels.push_back(want);
        pixels_taken++;
      end
      if (result_valid && !result_stall) begin
        got = '{filtered, saturated, frame_end};
        results_seen++;
        if (pending_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("result %0d with nothing pending: y=%0d sat=%0b end=%0b",
                     results_seen, filtered, saturated, frame_end);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("result %0d: expected y=%0d sat=%0b end=%0b, got y=%0d sat=%0b end=%0b",
                       results_seen, want.filtered, want.saturated, want.frame_end,
                       got.filtered, got.saturated, got.frame_end);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stall pattern, with an occasional long hold-off on request
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         served;
    mode         = SINK_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    served       = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_requests != served) begin
        served++;
        hold_left = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 4));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   result_stall <= 1'b0;
          SINK_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
          SINK_TOGGLE: result_stall <= ~result_stall;
          default:     result_stall <= ((mode_left % 16) < 5);
        endcase
      end
    end
  end

  task automatic write_reg(pptf_pkg::cfg_reg_e idx, logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic end_writes();
    if (cfg_we) cfg_we <= 1'b0;
  endtask

  // hold the sample side until every pending result is back
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic offer_pixel(pptf_pkg::sample_t x, bit typed, pixel_result_t want);
    int seen;
    seen      = pixels_taken;
    pin_typed = typed;
    pin_want  = want;
    sample       <= x;
    sample_valid <= 1'b1;
    do @(negedge clk); while (pixels_taken == seen);
  endtask

  function automatic void add_reg(pptf_pkg::cfg_reg_e idx, logic [23:0] data);
    stim_rows.push_back('{ROW_REG, idx, data, 1'b0, '0});
  endfunction

  function automatic void add_pix(pptf_pkg::sample_t x);
    stim_rows.push_back('{ROW_PIX, pptf_pkg::REG_GAIN_B0, x, 1'b0, '0});
  endfunction

  function automatic void add_pix_known(pptf_pkg::sample_t x, pptf_pkg::sample_t y,
                                        logic sat, logic fend);
    stim_rows.push_back('{ROW_PIX, pptf_pkg::REG_GAIN_B0, x, 1'b1, '{y, sat, fend}});
  endfunction

  function automatic pptf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return pptf_pkg::sample_t'($urandom);
      4, 5:       return pptf_pkg::sample_t'(int'($urandom_range(0, 65535)) - 32768);
      6:          return $urandom_range(0, 1) ? pptf_pkg::sample_t'(24'h7FFFFF)
                                              : pptf_pkg::sample_t'(24'h800000);
      default:    return pptf_pkg::sample_t'((int'($urandom_range(0, 64)) - 32) * 4096);
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 7))
      0, 1:       return 24'd65536;
      2, 3, 4:    return 24'(int'($urandom_range(0, 262144)) - 131072);
      5:          return 24'($urandom);
      default:    return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic logic [23:0] pick_fb(fb_mode_e fm, int k);
    case (fm)
      FB_OFF:    return '0;
      FB_STABLE: return 24'(int'($urandom_range(0, 32768 >> k)) - (16384 >> k));
      FB_WILD:   return 24'($urandom);
      default:   return (($urandom_range(0, 1) + k) % 2) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic logic [23:0] pick_frame_len();
    case ($urandom_range(0, 11))
      0:       return 24'd0;
      1:       return {9'($urandom), 15'($urandom_range(1, 8))};
      2:       return 24'd16384;
      3:       return 24'h007FFF;
      4:       return 24'($urandom_range(0, 32767));
      default: return 24'($urandom_range(1, 16));
    endcase
  endfunction

  // main sequence
  initial begin : stimulus
    fb_mode_e fm;
    bit       idle_on;
    int       burst_left;
    int       gap;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = pptf_pkg::REG_GAIN_B0;
    cfg_data      = '0;
    sample_valid  = 1'b0;
    sample        = '0;
    hold_requests = 0;
    pin_typed     = 1'b0;
    pin_want      = '0;
    clear_model();

    // directed rows: defaults, gain extremes, rounding ties, frame length corners
    add_pix_known(24'sd0, 24'sd0, 1'b0, 1'b0);
    add_pix_known(24'sd8388607, 24'sd8388607, 1'b0, 1'b0);
    add_pix_known(-24'sd8388608, -24'sd8388608, 1'b0, 1'b0);
    add_pix_known(24'sd1, 24'sd1, 1'b0, 1'b0);
    add_pix_known(-24'sd1, -24'sd1, 1'b0, 1'b0);
    add_reg(pptf_pkg::REG_GAIN_B0, 24'h7FFFFF);
    add_pix_known(24'sd8388607, 24'sd8388607, 1'b1, 1'b0);
    add_pix_known(-24'sd8388608, -24'sd8388608, 1'b1, 1'b0);
    add_reg(pptf_pkg::REG_GAIN_B0, 24'h800000);
    add_pix_known(-24'sd8388608, 24'sd8388607, 1'b1, 1'b0);
    add_pix_known(24'sd1, -24'sd128, 1'b0, 1'b0);
    add_reg(pptf_pkg::REG_GAIN_B0, 24'd32768);
    add_pix_known(24'sd1, 24'sd1, 1'b0, 1'b0);
    add_pix_known(-24'sd1, 24'sd0, 1'b0, 1'b0);
    // zero frame length, position already past the end
    add_reg(pptf_pkg::REG_PIXELS_PER_FRAME, 24'd0);
    add_pix_known(24'sd2, 24'sd1, 1'b0, 1'b1);
    // first order feedback on a single pixel frame
    add_reg(pptf_pkg::REG_GAIN_B0, 24'd65536);
    add_reg(pptf_pkg::REG_FB_COEF_1, 24'd32768);
    add_reg(pptf_pkg::REG_PIXELS_PER_FRAME, 24'd1);
    add_pix(24'sd4096);
    add_pix(24'sd4096);
    add_pix(24'sd4096);
    // feedback coefficients, several at their extremes
    add_reg(pptf_pkg::REG_FB_COEF_2, 24'h800000);
    add_reg(pptf_pkg::REG_FB_COEF_3, 24'h7FFFFF);
    add_reg(pptf_pkg::REG_FB_COEF_4, 24'hFF0000);
    add_reg(pptf_pkg::REG_FB_COEF_5, 24'd12345);
    add_reg(pptf_pkg::REG_FB_COEF_6, 24'h800000);
    add_pix(24'sd8388607);
    add_pix(24'sd8388607);
    add_pix(24'sd8388607);
    // oversized frame length, then junk above the register width
    add_reg(pptf_pkg::REG_PIXELS_PER_FRAME, 24'h007FFF);
    add_reg(pptf_pkg::REG_PIXELS_PER_FRAME, 24'hFF8003);
    add_pix(-24'sd5);
    add_pix(-24'sd5);
    // shrink the frame while the position sits past the new last pixel
    add_reg(pptf_pkg::REG_PIXELS_PER_FRAME, 24'd2);
    add_pix(24'sd777);
    add_pix(24'sd777);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        end_writes();
        offer_pixel(pptf_pkg::sample_t'(stim_rows[i].data), stim_rows[i].typed,
                    stim_rows[i].want);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      fm = fb_mode_e'($urandom_range(0, 3));
      if (ph == 0) fm = FB_STABLE;
      if (ph == RAND_PHASES - 1) fm = FB_EXTREME;
      for (int r = 0; r < 8; r++) begin
        case (pptf_pkg::cfg_reg_e'(r))
          pptf_pkg::REG_GAIN_B0:
            write_reg(pptf_pkg::REG_GAIN_B0, pick_gain());
          pptf_pkg::REG_PIXELS_PER_FRAME:
            write_reg(pptf_pkg::REG_PIXELS_PER_FRAME, pick_frame_len());
          default:
            write_reg(pptf_pkg::cfg_reg_e'(r), pick_fb(fm, r));
        endcase
      end
      end_writes();
      idle_on    = !(ph < 2 || ph == 2);
      burst_left = 0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (ph == 2 && n == 20) hold_requests <= hold_requests + 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = idle_on ? $urandom_range(0, 6) : 0;
          if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        offer_pixel(pick_sample(), 1'b0, '0);
      end
    end

    // let the tail drain
    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pptf_pkg.sv
rtl/pptf_hist_mem.sv
rtl/pptf_filter_dp.sv
rtl/per_pixel_iir_temporal_filter.sv
rtl/pptf_checker.sv
sim/per_pixel_iir_temporal_filter_test.sv
